FILE: hw/rtl/ffha_pkg.sv
package ffha_pkg;
   localparam int MaxSegmentsDefault = 64;
   localparam int AlignBytesDefault = 16;
   localparam int HeaderBytesDefault = 32;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_NOMEM = 3'd1,
      ST_ZERO = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_DOUBLE = 3'd4,
      ST_UNINIT = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_BUILD,
      CMD_LOAD,
      CMD_READ,
      CMD_WRITE
   } cmd_op_type;

   // controller to datapath
   typedef struct packed {
      cmd_op_type op;
      logic [1:0] wsel;
   } cmd_type;
endpackage

FILE: hw/rtl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator over an address-ordered segment table.
// req_ channel: tdata = {req_addr[64], req_size[32]}, tuser = req_type
// (0 allocate, 1 free). rsp_ channel: tdata = {pad, status[3],
// result_addr[64]}. One response per request, in order.
// csr_ APB port: heap_base at 0x0 (64 bit), heap_length at 0x8. Writing
// either rebuilds the table as one free segment; write only when idle.
// One request is worked at a time. An allocate scans the table, each
// entry visited through a read and a wait state, and on a split shifts
// the entries above it up by one; a free scans the same way and shifts
// the tail down on each merge. The table memory in the datapath has one
// write port and one registered read port.
// Reset leaves the heap uninitialized: every request answers status 5.
// The response is held in an output register until rsp_tready; the next
// request is accepted only once the response register is free.
module first_fit_heap_allocator_unit
   import ffha_pkg::*;
#(
   parameter int MAX_SEGMENTS = MaxSegmentsDefault,
   parameter int ALIGN_BYTES = AlignBytesDefault,
   parameter int HEADER_BYTES = HeaderBytesDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // req_size[31:0], req_addr[95:32]
   input  logic         req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // result_addr[63:0], status[66:64]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int AW = $clog2(MAX_SEGMENTS);

   logic [63:0] base_ff;
   logic [31:0] len_ff;
   logic csr_wr, cfg_we;
   logic busy, done, start;
   logic [63:0] res_addr;
   logic [2:0] res_status;
   logic op_ff;
   logic [31:0] size_ff;
   logic [63:0] addr_ff;
   logic go_ff;
   logic rv_ff;
   logic [66:0] rd_ff;
   logic cfg_go_ff;
   logic we, wused, rused;
   logic [AW-1:0] waddr, raddr;
   logic [31:0] woff, wsize, roff, rsize;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign cfg_we = csr_wr && (csr_paddr == 4'h0 || csr_paddr == 4'h8);
   assign csr_prdata = (csr_paddr == 4'h0) ? base_ff :
                       (csr_paddr == 4'h8) ? {32'd0, len_ff} : 64'd0;

   // registers update; the rebuild follows in the next cycle via cfg_go_ff
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         len_ff <= '0;
         cfg_go_ff <= 1'b0;
      end else begin
         cfg_go_ff <= cfg_we;
         if (csr_wr && csr_paddr == 4'h0) base_ff <= csr_pwdata;
         if (csr_wr && csr_paddr == 4'h8) len_ff <= csr_pwdata[31:0];
      end
   end

   assign req_tready = !busy && !go_ff && !rv_ff && !cfg_go_ff && !cfg_we;
   assign start = go_ff;

   // capture request, launch next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         go_ff <= req_tvalid && req_tready;
         if (done) rv_ff <= 1'b1;
         else if (rsp_tready) rv_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         op_ff <= req_tuser;
         size_ff <= req_tdata[31:0];
         addr_ff <= req_tdata[95:32];
      end
      if (done) rd_ff <= {res_status, (res_status == ST_OK) ? res_addr : 64'd0};
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {5'd0, rd_ff};

   ffha_controller #(
      .MAX_SEGMENTS(MAX_SEGMENTS), .ALIGN_BYTES(ALIGN_BYTES), .HEADER_BYTES(HEADER_BYTES)
   ) u_ctrl (
      .clock(clock), .reset(reset), .cfg_we(cfg_go_ff), .heap_base(base_ff),
      .heap_length(len_ff), .start(start), .op_free(op_ff), .size(size_ff),
      .addr(addr_ff), .busy(busy), .done(done), .res_addr(res_addr),
      .res_status(res_status), .we(we), .waddr(waddr), .woff(woff),
      .wsize(wsize), .wused(wused), .raddr(raddr), .roff(roff),
      .rsize(rsize), .rused(rused)
   );

   ffha_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
      .clock(clock), .we(we), .waddr(waddr), .woff(woff), .wsize(wsize),
      .wused(wused), .raddr(raddr), .roff(roff), .rsize(rsize), .rused(rused)
   );

   // no new request while a response waits
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while response pending");
   // any failed request returns a zero address
   a_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[66:64] != ST_OK) |-> rsp_tdata[63:0] == 64'd0)
      else $error("nonzero address on failure");
   // response stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
endmodule

FILE: hw/rtl/ffha_datapath.sv
module ffha_datapath
   import ffha_pkg::*;
#(
   parameter int MAX_SEGMENTS = MaxSegmentsDefault
) (
   input  logic        clock,
   input  logic        we,
   input  logic [$clog2(MAX_SEGMENTS)-1:0] waddr,
   input  logic [31:0] woff,
   input  logic [31:0] wsize,
   input  logic        wused,
   input  logic [$clog2(MAX_SEGMENTS)-1:0] raddr,
   output logic [31:0] roff,
   output logic [31:0] rsize,
   output logic        rused
);
   // segment table memory, one write and one registered read per cycle
   logic [64:0] mem [MAX_SEGMENTS];
   logic [64:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= {wused, wsize, woff};
      end
      rd_ff <= mem[raddr];
   end

   assign roff = rd_ff[31:0];
   assign rsize = rd_ff[63:32];
   assign rused = rd_ff[64];
endmodule

FILE: hw/rtl/ffha_controller.sv
module ffha_controller
   import ffha_pkg::*;
#(
   parameter int MAX_SEGMENTS = MaxSegmentsDefault,
   parameter int ALIGN_BYTES = AlignBytesDefault,
   parameter int HEADER_BYTES = HeaderBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cfg_we,
   input  logic [63:0] heap_base,
   input  logic [31:0] heap_length,
   input  logic        start,
   input  logic        op_free,
   input  logic [31:0] size,
   input  logic [63:0] addr,
   output logic        busy,
   output logic        done,
   output logic [63:0] res_addr,
   output logic [2:0]  res_status,
   output logic        we,
   output logic [$clog2(MAX_SEGMENTS)-1:0] waddr,
   output logic [31:0] woff,
   output logic [31:0] wsize,
   output logic        wused,
   output logic [$clog2(MAX_SEGMENTS)-1:0] raddr,
   input  logic [31:0] roff,
   input  logic [31:0] rsize,
   input  logic        rused
);
   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int AL = $clog2(ALIGN_BYTES);
   localparam int HdrSpan = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam logic [33:0] HDR = 34'(HdrSpan);
   localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_SRCHW, S_SPLIT, S_SHUP, S_SHUPW, S_MARK,
      S_FNEXT, S_FNEXTW, S_FPREV, S_FPREVW, S_SHDN, S_SHDNW, S_DONE
   } state_type;

   state_type state_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] i_ff, j_ff;
   logic [33:0] need_ff;
   logic [31:0] off_ff, sz_ff;
   logic [63:0] res_ff;
   logic [2:0] st_ff;
   logic merge_prev_ff;
   logic [63:0] start_addr;
   logic [AL-1:0] low;
   logic [32:0] wasted;
   logic [63:0] cand;
   logic [33:0] need_calc;

   // aligned heap start and lost padding
   assign low = heap_base[AL-1:0];
   assign start_addr = (low == '0) ? heap_base :
                       heap_base + 64'(ALIGN_BYTES) - 64'(low);
   assign wasted = (low == '0) ? 33'd0 : 33'(ALIGN_BYTES) - 33'(low);
   assign cand = start_addr + 64'(roff) + 64'(HdrSpan);
   assign need_calc = ({2'b0, size} + 34'(ALIGN_BYTES - 1)) & ~34'(ALIGN_BYTES - 1);

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);
   assign res_addr = res_ff;
   assign res_status = st_ff;

   // memory command decode
   always_comb begin
      we = 1'b0;
      waddr = i_ff[AW-1:0];
      woff = roff;
      wsize = rsize;
      wused = rused;
      raddr = i_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            raddr = '0;
            if (cfg_we) begin
               we = 1'b1;
               waddr = '0;
               woff = '0;
               wsize = 32'(33'(heap_length) - wasted - 33'(HdrSpan));
               wused = 1'b0;
            end
         end
         S_SRCH: raddr = i_ff[AW-1:0];
         S_SHUP: raddr = AW'(j_ff - 1'b1);
         S_SHUPW: begin
            we = 1'b1;
            waddr = j_ff[AW-1:0];
            raddr = AW'(j_ff - 2'd2);
         end
         S_SPLIT: begin
            we = 1'b1;
            waddr = AW'(i_ff + 1'b1);
            woff = 32'(34'(off_ff) + HDR + need_ff);
            wsize = 32'(34'(sz_ff) - HDR - need_ff);
            wused = 1'b0;
         end
         S_MARK: begin
            we = 1'b1;
            waddr = i_ff[AW-1:0];
            woff = off_ff;
            wsize = sz_ff;
            wused = 1'b1;
         end
         S_FNEXT: raddr = AW'(i_ff + 1'b1);
         S_FPREV: raddr = AW'(i_ff - 1'b1);
         S_SHDN: raddr = AW'(j_ff + 1'b1);
         S_SHDNW: begin
            we = 1'b1;
            waddr = j_ff[AW-1:0];
         end
         default: ;
      endcase
      // a free rewrites entry i as unused, merged with a free entry i+1; a free entry i-1 then absorbs it
      if (state_ff == S_FNEXTW && (i_ff + 1'b1 < count_ff) && !rused) begin
         we = 1'b1;
         waddr = i_ff[AW-1:0];
         woff = off_ff;
         wsize = 32'(34'(sz_ff) + HDR + 34'(rsize));
         wused = 1'b0;
      end else if (state_ff == S_FNEXTW) begin
         we = 1'b1;
         waddr = i_ff[AW-1:0];
         woff = off_ff;
         wsize = sz_ff;
         wused = 1'b0;
      end
      if (state_ff == S_FPREVW && i_ff != '0 && !rused) begin
         we = 1'b1;
         waddr = AW'(i_ff - 1'b1);
         woff = roff;
         wsize = 32'(34'(rsize) + HDR + 34'(sz_ff));
         wused = 1'b0;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cfg_we) begin
                  count_ff <= (33'(heap_length) <= wasted + 33'(HdrSpan)) ? '0 : CW'(1);
               end else if (start) begin
                  res_ff <= '0;
                  i_ff <= '0;
                  need_ff <= need_calc;
                  merge_prev_ff <= 1'b0;
                  if (count_ff == '0) begin
                     st_ff <= ST_UNINIT;
                     state_ff <= S_DONE;
                  end else if (!op_free && size == '0) begin
                     st_ff <= ST_ZERO;
                     state_ff <= S_DONE;
                  end else if (op_free && addr == '0) begin
                     st_ff <= ST_ZERO;
                     state_ff <= S_DONE;
                  end else begin
                     st_ff <= op_free ? ST_UNKNOWN : ST_NOMEM;
                     state_ff <= S_SRCH;
                  end
               end
            end
            S_SRCH: state_ff <= S_SRCHW;
            S_SRCHW: begin
               off_ff <= roff;
               sz_ff <= rsize;
               if (op_free) begin
                  if (cand == addr) begin
                     if (!rused) begin
                        st_ff <= ST_DOUBLE;
                        state_ff <= S_DONE;
                     end else begin
                        st_ff <= ST_OK;
                        state_ff <= S_FNEXT;
                     end
                  end else if (i_ff + 1'b1 >= count_ff) begin
                     state_ff <= S_DONE;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                     state_ff <= S_SRCH;
                  end
               end else if (!rused && 34'(rsize) >= need_ff) begin
                  st_ff <= ST_OK;
                  res_ff <= cand;
                  if (34'(rsize) >= need_ff + HDR + 34'(ALIGN_BYTES) && count_ff < MAXC) begin
                     j_ff <= count_ff;
                     state_ff <= S_SHUP;
                  end else begin
                     state_ff <= S_MARK;
                  end
               end else if (i_ff + 1'b1 >= count_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  state_ff <= S_SRCH;
               end
            end
            S_SHUP: begin
               if (j_ff > i_ff + 1'b1) state_ff <= S_SHUPW;
               else state_ff <= S_SPLIT;
            end
            S_SHUPW: begin
               j_ff <= j_ff - 1'b1;
               if (j_ff - 1'b1 > i_ff + 1'b1) state_ff <= S_SHUPW;
               else state_ff <= S_SPLIT;
            end
            S_SPLIT: begin
               count_ff <= count_ff + 1'b1;
               sz_ff <= 32'(need_ff);
               state_ff <= S_MARK;
            end
            S_MARK: state_ff <= S_DONE;
            S_FNEXT: state_ff <= S_FNEXTW;
            S_FNEXTW: begin
               if ((i_ff + 1'b1 < count_ff) && !rused) begin
                  sz_ff <= 32'(34'(sz_ff) + HDR + 34'(rsize));
                  j_ff <= i_ff + 1'b1;
                  state_ff <= S_SHDN;
               end else begin
                  state_ff <= S_FPREV;
               end
            end
            S_FPREV: state_ff <= S_FPREVW;
            S_FPREVW: begin
               if (i_ff != '0 && !rused) begin
                  j_ff <= i_ff;
                  merge_prev_ff <= 1'b1;
                  state_ff <= S_SHDN;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_SHDN: begin
               if (j_ff + 1'b1 < count_ff) state_ff <= S_SHDNW;
               else begin
                  count_ff <= count_ff - 1'b1;
                  // after the next-merge go check the previous neighbor
                  state_ff <= merge_prev_ff ? S_DONE : S_FPREV;
               end
            end
            S_SHDNW: begin
               j_ff <= j_ff + 1'b1;
               state_ff <= S_SHDN;
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
